### hw/rtl/avns_pkg.sv
// ----------------------------------------------------------------------------
// avns_pkg
// shared types and constants of the active note voice scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package avns_pkg;

  typedef enum logic [1:0] {
    FN_BEGIN = 2'd0,
    FN_NOTE  = 2'd1,
    FN_END   = 2'd2,
    FN_RALL  = 2'd3
  } func_t;

  localparam int LEN_W   = 13;
  localparam int FT_W    = 40;
  localparam int OFF_W   = 12;
  localparam int RC_W    = 5;
  localparam int RC_MAX  = 31;
  localparam int PITCHES = 128;

  // one queued input word after classification
  typedef struct packed {
    func_t             func;
    logic [LEN_W-1:0]  len;
    logic              run;
    logic [6:0]        prog;
    logic [6:0]        pitch;
    logic [6:0]        vel;
    logic [FT_W-1:0]   tstart;
    logic [FT_W-1:0]   tend;
  } item_t;

  // one result word
  typedef struct packed {
    logic              on;
    logic [6:0]        prog;
    logic [6:0]        pitch;
    logic [6:0]        vel;
    logic [OFF_W-1:0]  off;
    logic              wire_ev;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP,
    ST_MATCH,
    ST_FULL,
    ST_START,
    ST_RALL,
    ST_WR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/active_note_voice_scheduler.sv
// ----------------------------------------------------------------------------
// active_note_voice_scheduler
// oldest-steal voice table with per-pitch wire counts for one block stream
// ----------------------------------------------------------------------------
// sequencing: one word at a time; a new word is taken from the queue only
//   after the last one has finished its table walk and pitch count ram
//   round trips and its final result has gone to the output register
// reset: synchronous, clears the queue, table count, times, pitch valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module active_note_voice_scheduler #(
  parameter int MAX_SOUNDING = 16,
  parameter int PITCH_SLOTS  = 128,
  parameter int MAX_BLOCK    = 4096,
  parameter int TIME_BITS    = 40
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input word channel
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [12:0] block_length,
  input  wire logic        transport_running,
  input  wire logic [6:0]  note_program,
  input  wire logic [6:0]  note_pitch,
  input  wire logic [6:0]  note_velocity,
  input  wire logic [39:0] note_start_time,
  input  wire logic [39:0] note_end_time,
  // result word channel
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        is_note_on,
  output      logic [6:0]  out_program,
  output      logic [6:0]  out_pitch,
  output      logic [6:0]  out_velocity,
  output      logic [11:0] sample_offset,
  output      logic        wire_event,
  output      logic        last
);

  // queue between the front and the sequencer
  logic            q_valid;
  logic            q_pop;
  avns_pkg::item_t q_item;
  avns_pkg::res_t  res;

  // pitch table width is fixed by the seven bit pitch field
  logic [$clog2(PITCH_SLOTS)-1:0] unused_pitch_idx;
  assign unused_pitch_idx = note_pitch[$clog2(PITCH_SLOTS)-1:0];

  avns_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .block_length      (block_length),
    .transport_running (transport_running),
    .note_program      (note_program),
    .note_pitch        (unused_pitch_idx),
    .note_velocity     (note_velocity),
    .note_start_time   (note_start_time),
    .note_end_time     (note_end_time),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item)
  );

  // sequencer owns the voice table, the pitch count ram and the output register
  avns_back #(
    .MAX_SOUNDING (MAX_SOUNDING),
    .TIME_BITS    (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (last)
  );

  assign is_note_on    = res.on;
  assign out_program   = res.prog;
  assign out_pitch     = res.pitch;
  assign out_velocity  = res.vel;
  assign sample_offset = res.off;
  assign wire_event    = res.wire_ev;

endmodule

`default_nettype wire

### hw/rtl/avns_ram.sv
// ----------------------------------------------------------------------------
// avns_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module avns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/avns_front.sv
// ----------------------------------------------------------------------------
// avns_front
// accepts input words, clamps block length and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module avns_front #(
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [1:0]                    func,
  input  wire logic [avns_pkg::LEN_W-1:0]    block_length,
  input  wire logic                          transport_running,
  input  wire logic [6:0]                    note_program,
  input  wire logic [6:0]                    note_pitch,
  input  wire logic [6:0]                    note_velocity,
  input  wire logic [avns_pkg::FT_W-1:0]     note_start_time,
  input  wire logic [avns_pkg::FT_W-1:0]     note_end_time,
  output      logic                          q_valid,
  input  wire logic                          q_pop,
  output      avns_pkg::item_t               q_item
);

  avns_pkg::item_t fifo [2];
  avns_pkg::item_t in_item;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;

  always_comb begin
    in_item.func   = avns_pkg::func_t'(func);
    // long blocks are taken as the largest block
    in_item.len    = (32'(block_length) > MAX_BLOCK) ? avns_pkg::LEN_W'(MAX_BLOCK)
                                                     : block_length;
    in_item.run    = transport_running;
    in_item.prog   = note_program;
    in_item.pitch  = note_pitch;
    in_item.vel    = note_velocity;
    in_item.tstart = note_start_time;
    in_item.tend   = note_end_time;
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/avns_back.sv
// ----------------------------------------------------------------------------
// avns_back
// voice table sequencer: expiry walk, retrigger, steal, start, release all
// ----------------------------------------------------------------------------
`default_nettype none

module avns_back #(
  parameter int MAX_SOUNDING = 16,
  parameter int TIME_BITS    = 40
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output      logic                        q_pop,
  input  wire avns_pkg::item_t             q_item,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      avns_pkg::res_t              out_res,
  output      logic                        out_last
);

  localparam int CW = $clog2(MAX_SOUNDING + 1);
  localparam int IW = (MAX_SOUNDING > 1) ? $clog2(MAX_SOUNDING) : 1;
  localparam int PW = $clog2(avns_pkg::PITCHES);

  logic [6:0]           slot_prog  [MAX_SOUNDING];
  logic [6:0]           slot_pitch [MAX_SOUNDING];
  logic [TIME_BITS-1:0] slot_end   [MAX_SOUNDING];
  logic [CW-1:0]        count;
  logic                 running;
  logic [TIME_BITS-1:0] bs;
  logic [TIME_BITS-1:0] be;
  avns_pkg::item_t      cur;
  logic [avns_pkg::OFF_W-1:0] note_off;
  logic [CW-1:0]        exp_i;
  logic [avns_pkg::PITCHES-1:0] vbits;

  avns_pkg::state_t     state, state_next, ret_state, ret_next;

  logic                 act_on;
  logic [IW-1:0]        act_idx;
  logic [6:0]           act_prog;
  logic [6:0]           act_pitch;
  logic [6:0]           act_vel;
  logic [avns_pkg::OFF_W-1:0] act_off;

  avns_pkg::res_t       pend;
  logic                 pend_valid;

  // sequencer strobes
  logic                 load, rel, st, exp_inc, end_blk, commit, push, push_last;
  logic [IW-1:0]        rel_idx;
  logic [avns_pkg::OFF_W-1:0] rel_off;
  logic                 can_push;
  logic                 found;
  logic [IW-1:0]        midx;
  logic [IW-1:0]        ei;

  logic [avns_pkg::RC_W-1:0] rd_data, rc_cur, rc_new;
  logic                 wire_new;
  logic                 rd_en;
  logic [PW-1:0]        rd_addr;

  function automatic logic [avns_pkg::OFF_W-1:0] calc_off(
    input logic [TIME_BITS-1:0]       t,
    input logic [TIME_BITS-1:0]       base,
    input logic [avns_pkg::LEN_W-1:0] len
  );
    logic [TIME_BITS-1:0] d;
    logic [TIME_BITS-1:0] lm1;
    d   = t - base;
    lm1 = TIME_BITS'(len) - TIME_BITS'(1);
    if (len == '0 || t <= base) begin
      return '0;
    end
    return (d > lm1) ? lm1[avns_pkg::OFF_W-1:0] : d[avns_pkg::OFF_W-1:0];
  endfunction

  assign can_push = !out_valid || out_ready;
  assign ei       = exp_i[IW-1:0];

  // first sounding entry of the same program and pitch
  always_comb begin
    found = 1'b0;
    midx  = '0;
    for (int j = 0; j < MAX_SOUNDING; j++) begin
      if (!found && CW'(j) < count && slot_prog[j] == cur.prog &&
          slot_pitch[j] == cur.pitch) begin
        found = 1'b1;
        midx  = IW'(j);
      end
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    load       = 1'b0;
    rel        = 1'b0;
    st         = 1'b0;
    exp_inc    = 1'b0;
    end_blk    = 1'b0;
    commit     = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    q_pop      = 1'b0;
    rel_idx    = '0;
    rel_off    = '0;
    unique case (state)
      avns_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          load  = 1'b1;
          unique case (q_item.func)
            avns_pkg::FN_BEGIN: state_next = q_item.run ? avns_pkg::ST_EXP
                                                        : avns_pkg::ST_DONE;
            avns_pkg::FN_NOTE:  state_next = (running && TIME_BITS'(q_item.tend) > bs)
                                             ? avns_pkg::ST_MATCH : avns_pkg::ST_DONE;
            avns_pkg::FN_END:   state_next = running ? avns_pkg::ST_EXP
                                                     : avns_pkg::ST_DONE;
            avns_pkg::FN_RALL:  state_next = avns_pkg::ST_RALL;
            default:            state_next = avns_pkg::ST_DONE;
          endcase
        end
      end
      avns_pkg::ST_EXP: begin
        if (exp_i >= count) begin
          end_blk    = (cur.func == avns_pkg::FN_END);
          state_next = avns_pkg::ST_DONE;
        end else if (slot_end[ei] < be) begin
          rel        = 1'b1;
          rel_idx    = ei;
          rel_off    = calc_off(slot_end[ei], bs, cur.len);
          ret_next   = avns_pkg::ST_EXP;
          state_next = avns_pkg::ST_WR;
        end else begin
          exp_inc = 1'b1;
        end
      end
      avns_pkg::ST_MATCH: begin
        if (found) begin
          rel        = 1'b1;
          rel_idx    = midx;
          rel_off    = note_off;
          ret_next   = avns_pkg::ST_FULL;
          state_next = avns_pkg::ST_WR;
        end else begin
          state_next = avns_pkg::ST_FULL;
        end
      end
      avns_pkg::ST_FULL: begin
        if (count == CW'(MAX_SOUNDING)) begin
          rel        = 1'b1;
          rel_off    = note_off;
          ret_next   = avns_pkg::ST_START;
          state_next = avns_pkg::ST_WR;
        end else begin
          state_next = avns_pkg::ST_START;
        end
      end
      avns_pkg::ST_START: begin
        st         = 1'b1;
        ret_next   = avns_pkg::ST_DONE;
        state_next = avns_pkg::ST_WR;
      end
      avns_pkg::ST_RALL: begin
        if (count != '0) begin
          rel        = 1'b1;
          rel_idx    = IW'(count - CW'(1));
          ret_next   = avns_pkg::ST_RALL;
          state_next = avns_pkg::ST_WR;
        end else begin
          state_next = avns_pkg::ST_DONE;
        end
      end
      avns_pkg::ST_WR: begin
        if (!(pend_valid && !can_push)) begin
          commit     = 1'b1;
          push       = pend_valid;
          state_next = ret_state;
        end
      end
      avns_pkg::ST_DONE: begin
        if (!pend_valid) begin
          state_next = avns_pkg::ST_IDLE;
        end else if (can_push) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = avns_pkg::ST_IDLE;
        end
      end
      default: state_next = avns_pkg::ST_IDLE;
    endcase
  end

  // pitch count read goes out with the action, data is back in the write state
  assign rd_en   = rel || st;
  assign rd_addr = rel ? PW'(slot_pitch[rel_idx]) : PW'(cur.pitch);

  avns_ram #(
    .WIDTH (avns_pkg::RC_W),
    .DEPTH (avns_pkg::PITCHES)
  ) u_rc_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (PW'(act_pitch)),
    .wdata (rc_new),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    rc_cur = vbits[PW'(act_pitch)] ? rd_data : '0;
    if (act_on) begin
      wire_new = (rc_cur == '0);
      rc_new   = (rc_cur < avns_pkg::RC_W'(avns_pkg::RC_MAX)) ? rc_cur + 1'b1 : rc_cur;
    end else if (rc_cur != '0) begin
      wire_new = (rc_cur == avns_pkg::RC_W'(1));
      rc_new   = rc_cur - 1'b1;
    end else begin
      wire_new = 1'b0;
      rc_new   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur      <= q_item;
      exp_i    <= '0;
      note_off <= calc_off(TIME_BITS'(q_item.tstart), bs, q_item.len);
    end
    if (exp_inc) begin
      exp_i <= exp_i + 1'b1;
    end
    if (rel || st) begin
      ret_state <= ret_next;
      act_on    <= st;
      act_idx   <= rel_idx;
      act_prog  <= rel ? slot_prog[rel_idx]  : cur.prog;
      act_pitch <= rel ? slot_pitch[rel_idx] : cur.pitch;
      act_vel   <= rel ? 7'd0 : cur.vel;
      act_off   <= rel ? rel_off : note_off;
    end
    if (commit) begin
      pend.on      <= act_on;
      pend.prog    <= act_prog;
      pend.pitch   <= act_pitch;
      pend.vel     <= act_vel;
      pend.off     <= act_off;
      pend.wire_ev <= wire_new;
      if (act_on) begin
        slot_prog[IW'(count)]  <= cur.prog;
        slot_pitch[IW'(count)] <= cur.pitch;
        slot_end[IW'(count)]   <= TIME_BITS'(cur.tend);
      end else begin
        // close the gap, entries above the count are never read
        for (int j = 0; j < MAX_SOUNDING - 1; j++) begin
          if (IW'(j) >= act_idx) begin
            slot_prog[j]  <= slot_prog[j+1];
            slot_pitch[j] <= slot_pitch[j+1];
            slot_end[j]   <= slot_end[j+1];
          end
        end
      end
    end
    if (push) begin
      out_res  <= pend;
      out_last <= push_last;
    end
    if (rst) begin
      count      <= '0;
      running    <= 1'b0;
      bs         <= '0;
      be         <= '0;
      vbits      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load && q_item.func == avns_pkg::FN_BEGIN) begin
        running <= q_item.run;
        if (q_item.run) begin
          be <= bs + TIME_BITS'(q_item.len);
        end
      end
      if (end_blk) begin
        bs <= be;
      end
      if (commit) begin
        vbits[PW'(act_pitch)] <= 1'b1;
        pend_valid            <= 1'b1;
        count                 <= act_on ? count + 1'b1 : count - 1'b1;
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/avns_checker.sv
// ----------------------------------------------------------------------------
// avns_checker
// port level checks of the voice scheduler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module avns_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_note_on,
  input wire logic [6:0]  out_program,
  input wire logic [6:0]  out_pitch,
  input wire logic [6:0]  out_velocity,
  input wire logic [11:0] sample_offset,
  input wire logic        wire_event,
  input wire logic        last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_pitch) && $stable(sample_offset) &&
      $stable(last) && $stable(is_note_on))
    else $error("stalled result word changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_release_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_note_on |-> out_velocity == 7'd0)
    else $error("release carries a velocity");

  a_start_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_note_on |-> last)
    else $error("note start is not the final word");

endmodule

bind active_note_voice_scheduler avns_checker u_avns_checker (.*);

`default_nettype wire
